// ===== rtl/core/mh_pkg.sv =====
// Shared constants, types and lookup functions for the magnetometer heading pipeline.
`default_nettype none

package mh_pkg;

    localparam int CORDIC_STEPS   = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int CORDIC_MAX     = 24;
    localparam int CORDIC_RUN     = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;

    localparam int SAMPLE_W    = 13;
    localparam int OFF_W       = 16;
    localparam int COEF_W      = 16;
    localparam int HEAD_W      = 15;
    localparam int MAG_W       = 23;  // |count| * 1600
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 32;
    localparam int CPG_W       = 11;
    localparam int QUOT_W      = 15;
    localparam int BACK_W      = QUOT_W + CPG_W;
    localparam int VEC_W       = 18;
    localparam int PROD_W      = COEF_W + VEC_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int XY_W        = DOT_W + 2;
    localparam int ANG_W       = 28;  // 1/65536 degree
    localparam int CFG_W       = 48;
    localparam int GAIN_W      = 3;
    localparam int IDX_W       = 2;

    localparam logic [IDX_W-1:0] REG_GAIN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_OFFS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROT_X = 2'd2;
    localparam logic [IDX_W-1:0] REG_ROT_Y = 2'd3;

    localparam logic [CFG_W-1:0] ROT_X_RESET = CFG_W'(1) << COEF_FRAC_BITS;
    localparam logic [CFG_W-1:0] ROT_Y_RESET = CFG_W'(1) << (COEF_FRAC_BITS + OFF_W);

    localparam logic signed [ANG_W-1:0] HALF_TURN  = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] ROUND_HALF = ANG_W'(512);
    localparam int                      ROUND_SH   = 10;
    localparam logic signed [ANG_W-1:0] FULL_Q6    = ANG_W'(23040);

    typedef struct packed {
        logic                    vld;
        logic                    zero;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } mh_cordic_t;

    // counts per gauss; steps above six saturate
    function automatic logic [CPG_W-1:0] cpg(input logic [GAIN_W-1:0] g, input logic is_z);
        logic [CPG_W-1:0] c;
        unique case (g)
            3'd0:    c = is_z ? CPG_W'(980) : CPG_W'(1100);
            3'd1:    c = is_z ? CPG_W'(760) : CPG_W'(855);
            3'd2:    c = is_z ? CPG_W'(600) : CPG_W'(670);
            3'd3:    c = is_z ? CPG_W'(400) : CPG_W'(450);
            3'd4:    c = is_z ? CPG_W'(255) : CPG_W'(400);
            3'd5:    c = is_z ? CPG_W'(295) : CPG_W'(330);
            default: c = is_z ? CPG_W'(205) : CPG_W'(230);
        endcase
        return c;
    endfunction

    // floor(2^32 / cpg)
    function automatic logic [RECIP_W-1:0] recip(input logic [GAIN_W-1:0] g, input logic is_z);
        logic [RECIP_W-1:0] r;
        unique case (g)
            3'd0:    r = is_z ? RECIP_W'(4382619)  : RECIP_W'(3904515);
            3'd1:    r = is_z ? RECIP_W'(5651272)  : RECIP_W'(5023353);
            3'd2:    r = is_z ? RECIP_W'(7158278)  : RECIP_W'(6410398);
            3'd3:    r = is_z ? RECIP_W'(10737418) : RECIP_W'(9544371);
            3'd4:    r = is_z ? RECIP_W'(16843009) : RECIP_W'(10737418);
            3'd5:    r = is_z ? RECIP_W'(14559211) : RECIP_W'(13015052);
            default: r = is_z ? RECIP_W'(20951059) : RECIP_W'(18673770);
        endcase
        return r;
    endfunction

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
        logic signed [ANG_W-1:0] a;
        unique case (i)
            0:       a = ANG_W'(2949120);
            1:       a = ANG_W'(1740967);
            2:       a = ANG_W'(919879);
            3:       a = ANG_W'(466945);
            4:       a = ANG_W'(234379);
            5:       a = ANG_W'(117304);
            6:       a = ANG_W'(58666);
            7:       a = ANG_W'(29335);
            8:       a = ANG_W'(14668);
            9:       a = ANG_W'(7334);
            10:      a = ANG_W'(3667);
            11:      a = ANG_W'(1833);
            12:      a = ANG_W'(917);
            13:      a = ANG_W'(458);
            14:      a = ANG_W'(229);
            15:      a = ANG_W'(115);
            16:      a = ANG_W'(57);
            17:      a = ANG_W'(29);
            18:      a = ANG_W'(14);
            19:      a = ANG_W'(7);
            20:      a = ANG_W'(4);
            21:      a = ANG_W'(2);
            22:      a = ANG_W'(1);
            default: a = ANG_W'(0);
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/magnetometer_heading.sv =====
// Top level: gain scaling, offset removal, rotation, CORDIC heading and output register.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    s_tdata: sample_x, sample_y, sample_z
//  m_       out  m_tvalid / m_tready    m_tdata: heading_q6
//  cfg_     in   cfg_wr_en              cfg_index, cfg_wdata
//
// One sample per cycle while the output is not stalled; 8 front stages, CORDIC_STEPS CORDIC
// stages and 1 output stage. The front end divides by counts-per-gauss with a
// reciprocal multiply and one correction step, which sets the front-stage count.
// Reset (aresetn low, synchronous) clears all valid bits and loads the default registers.
// A stalled output beat freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module magnetometer_heading
    import mh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [39:0]       s_tdata,   // [12:0] sample_x, [25:13] sample_y, [38:26] sample_z
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [15:0]       m_tdata,   // [14:0] heading_q6
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    logic [GAIN_W-1:0] gain_reg;
    logic [CFG_W-1:0]  offs_reg;
    logic [CFG_W-1:0]  rot_x_reg;
    logic [CFG_W-1:0]  rot_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= '0;
            offs_reg  <= '0;
            rot_x_reg <= ROT_X_RESET;
            rot_y_reg <= ROT_Y_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_OFFS:  offs_reg  <= cfg_wdata;
                REG_ROT_X: rot_x_reg <= cfg_wdata;
                REG_ROT_Y: rot_y_reg <= cfg_wdata;
            endcase
        end
    end

    logic adv;
    logic m_valid_reg;
    logic [HEAD_W-1:0] head_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, head_reg};

    // valid bits of the front stages
    logic [6:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[5:0], s_tvalid};
        end
    end

    logic [MAG_W-1:0]         mag1_reg  [3];
    logic [2:0]               neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [MAG_W-1:0]         mag2_reg  [3];
    logic [QUOT_W-1:0]        quo2_reg  [3];
    logic [MAG_W-1:0]         mag3_reg  [3];
    logic [QUOT_W-1:0]        quo3_reg  [3];
    logic [BACK_W-1:0]        back3_reg [3];
    logic [QUOT_W-1:0]        quo4_reg  [3];
    logic signed [VEC_W-1:0]  vec5_reg  [3];
    logic signed [PROD_W-1:0] px6_reg   [3];
    logic signed [PROD_W-1:0] py6_reg   [3];
    logic signed [DOT_W-1:0]  dx7_reg, dy7_reg;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        localparam logic IS_Z = (k == 2);
        logic signed [SAMPLE_W-1:0]     smp;
        logic [SAMPLE_W-1:0]            smp_abs;
        logic [MAG_W-1:0]               mag1_next;
        logic [MAG_W+RECIP_W-1:0]       rprod;
        logic [BACK_W-1:0]              back3_next;
        logic [MAG_W-1:0]               rem;
        logic [QUOT_W-1:0]              quo4_next;
        logic signed [VEC_W-1:0]        qext;
        logic signed [VEC_W-1:0]        vec5_next;
        logic signed [OFF_W-1:0]        off;
        logic signed [COEF_W-1:0]       cx, cy;

        assign smp       = s_tdata[k*SAMPLE_W +: SAMPLE_W];
        assign smp_abs   = smp[SAMPLE_W-1] ? SAMPLE_W'(-smp) : SAMPLE_W'(smp);
        // 1600 = 1024 + 512 + 64
        assign mag1_next = (MAG_W'(smp_abs) << 10) + (MAG_W'(smp_abs) << 9)
                         + (MAG_W'(smp_abs) << 6);
        assign rprod      = (MAG_W+RECIP_W)'(mag1_reg[k])
                          * (MAG_W+RECIP_W)'(recip(gain_reg, IS_Z));
        assign back3_next = BACK_W'(quo2_reg[k]) * BACK_W'(cpg(gain_reg, IS_Z));
        // estimate is low by at most one
        assign rem        = mag3_reg[k] - back3_reg[k][MAG_W-1:0];
        assign quo4_next  = quo3_reg[k] + QUOT_W'(rem >= MAG_W'(cpg(gain_reg, IS_Z)));
        assign off        = $signed(offs_reg[k*OFF_W +: OFF_W]);
        assign qext       = $signed(VEC_W'(quo4_reg[k]));
        assign vec5_next  = (neg4_reg[k] ? -qext : qext) - VEC_W'(off);
        assign cx         = $signed(rot_x_reg[k*COEF_W +: COEF_W]);
        assign cy         = $signed(rot_y_reg[k*COEF_W +: COEF_W]);

        always_ff @(posedge aclk) begin
            if (adv) begin
                mag1_reg[k]  <= mag1_next;
                neg1_reg[k]  <= smp[SAMPLE_W-1];
                mag2_reg[k]  <= mag1_reg[k];
                quo2_reg[k]  <= rprod[RECIP_SHIFT +: QUOT_W];
                neg2_reg[k]  <= neg1_reg[k];
                mag3_reg[k]  <= mag2_reg[k];
                quo3_reg[k]  <= quo2_reg[k];
                back3_reg[k] <= back3_next;
                neg3_reg[k]  <= neg2_reg[k];
                quo4_reg[k]  <= quo4_next;
                neg4_reg[k]  <= neg3_reg[k];
                vec5_reg[k]  <= vec5_next;
                px6_reg[k]   <= cx * vec5_reg[k];
                py6_reg[k]   <= cy * vec5_reg[k];
            end
        end
    end

    logic signed [DOT_W-1:0] dx7_next, dy7_next;
    assign dx7_next = DOT_W'(px6_reg[0]) + DOT_W'(px6_reg[1]) + DOT_W'(px6_reg[2]);
    assign dy7_next = DOT_W'(py6_reg[0]) + DOT_W'(py6_reg[1]) + DOT_W'(py6_reg[2]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx7_reg <= dx7_next;
            dy7_reg <= dy7_next;
        end
    end

    // fold into the right half plane before the CORDIC
    mh_cordic_t cin_reg, cin_next, cout;
    logic signed [XY_W-1:0] xe, ye;

    assign xe = XY_W'(dx7_reg);
    assign ye = XY_W'(dy7_reg);

    always_comb begin
        cin_next.vld  = vld_reg[6];
        cin_next.zero = (dx7_reg == '0) && (dy7_reg == '0);
        if (dx7_reg[DOT_W-1]) begin
            cin_next.x = -xe;
            cin_next.y = -ye;
            cin_next.z = HALF_TURN;
        end else begin
            cin_next.x = xe;
            cin_next.y = ye;
            cin_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cin_reg.vld <= 1'b0;
        end else if (adv) begin
            cin_reg <= cin_next;
        end
    end

    mh_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .din     (cin_reg),
        .dout    (cout)
    );

    // round half up to 1/64 degree, wrap into one turn
    logic signed [ANG_W-1:0] ang_rnd;
    logic signed [ANG_W-1:0] ang_wrap;
    logic [HEAD_W-1:0]       head_next;

    assign ang_rnd = (cout.z + ROUND_HALF) >>> ROUND_SH;

    always_comb begin
        priority if (ang_rnd[ANG_W-1]) begin
            ang_wrap = ang_rnd + FULL_Q6;
        end else if (ang_rnd >= FULL_Q6) begin
            ang_wrap = ang_rnd - FULL_Q6;
        end else begin
            ang_wrap = ang_rnd;
        end
        head_next = cout.zero ? '0 : ang_wrap[HEAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= cout.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            head_reg <= head_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mh_cordic.sv =====
// Vectoring CORDIC pipeline, one micro-rotation per register stage.
`default_nettype none

module mh_cordic
    import mh_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       adv,
    input  wire mh_cordic_t din,
    output      mh_cordic_t dout
);

    mh_cordic_t st_reg  [CORDIC_RUN];
    mh_cordic_t st_next [CORDIC_RUN];

    for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_step
        mh_cordic_t              prev;
        logic signed [XY_W-1:0]  dx;
        logic signed [XY_W-1:0]  dy;
        logic                    y_pos;

        if (i == 0) begin : g_first
            assign prev = din;
        end else begin : g_rest
            assign prev = st_reg[i-1];
        end

        assign dx    = prev.y >>> i;
        assign dy    = prev.x >>> i;
        assign y_pos = !prev.y[XY_W-1] && (prev.y != '0);

        always_comb begin
            st_next[i]      = prev;
            if (y_pos) begin
                st_next[i].x = prev.x + dx;
                st_next[i].y = prev.y - dy;
                st_next[i].z = prev.z + atan_q16(i);
            end else begin
                st_next[i].x = prev.x - dx;
                st_next[i].y = prev.y + dy;
                st_next[i].z = prev.z - atan_q16(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[i].vld <= 1'b0;
            end else if (adv) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign dout = st_reg[CORDIC_RUN-1];

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for magnetometer_heading: directed table, then randomized phases.
module testbench;
    import mh_pkg::*;

    localparam int     PIPE_LAT       = 25;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     PHASE_ITEMS    = 130;
    localparam int     NUM_PHASES     = 8;
    localparam int     CORDIC_ITERS   = CORDIC_RUN;
    localparam longint UT16_PER_GAUSS = 1600;
    localparam longint HALF_TURN_Q16  = 180 * 65536;
    localparam longint ROUND_BIAS     = 512 + 23040 * 2048;  // half step plus two turns
    localparam longint Q6_PER_STEP    = 1024;
    localparam longint Q6_TURN        = 23040;

    typedef struct {
        logic [GAIN_W-1:0]   gain;
        logic signed [12:0]  sx;
        logic signed [12:0]  sy;
        logic signed [12:0]  sz;
        bit                  known;
        logic [HEAD_W-1:0]   heading;
    } sample_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;    // [12:0] sample_x, [25:13] sample_y, [38:26] sample_z
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;           // [14:0] heading_q6
    logic                 cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]     cfg_index = REG_GAIN;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // what the block is currently set to
    logic [GAIN_W-1:0]    gain_sh = '0;
    logic [CFG_W-1:0]     offs_sh = '0;
    logic [CFG_W-1:0]     rowx_sh = ROT_X_RESET;
    logic [CFG_W-1:0]     rowy_sh = ROT_Y_RESET;

    longint               cpg_xy_lut [0:6] = '{1100, 855, 670, 450, 400, 330, 230};
    longint               cpg_z_lut  [0:6] = '{980, 760, 600, 400, 255, 295, 205};
    longint               atan_lut   [0:23] = '{2949120, 1740967, 919879, 466945, 234379,
                                               117304, 58666, 29335, 14668, 7334, 3667,
                                               1833, 917, 458, 229, 115, 57, 29, 14, 7,
                                               4, 2, 1, 0};

    logic [HEAD_W-1:0]    heading_q [$];
    sample_row_t          sample_rows [$];
    logic [HEAD_W-1:0]    want;
    int                   errors        = 0;
    int                   idle_in_pct   = 10;
    int                   stall_out_pct = 82;
    int                   quiet_cycles  = 0;

    magnetometer_heading u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint lane16(input logic [CFG_W-1:0] r, input int k);
        logic signed [15:0] v;
        v = r[16*k +: 16];
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pack_row(input int c0, input int c1, input int c2);
        return {16'(c2), 16'(c1), 16'(c0)};
    endfunction

    function automatic logic [CFG_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [HEAD_W-1:0] predict_heading(input logic signed [12:0] sx,
                                                          input logic signed [12:0] sy,
                                                          input logic signed [12:0] sz);
        longint vec [3];
        longint xr, yr, ang, dx, dy, t;
        int     g;
        int     i;
        g = (gain_sh > 3'd6) ? 6 : int'(gain_sh);   // step seven saturates
        vec[0] = longint'(sx) * UT16_PER_GAUSS / cpg_xy_lut[g] - lane16(offs_sh, 0);
        vec[1] = longint'(sy) * UT16_PER_GAUSS / cpg_xy_lut[g] - lane16(offs_sh, 1);
        vec[2] = longint'(sz) * UT16_PER_GAUSS / cpg_z_lut[g] - lane16(offs_sh, 2);
        xr = lane16(rowx_sh, 0) * vec[0] + lane16(rowx_sh, 1) * vec[1]
           + lane16(rowx_sh, 2) * vec[2];
        yr = lane16(rowy_sh, 0) * vec[0] + lane16(rowy_sh, 1) * vec[1]
           + lane16(rowy_sh, 2) * vec[2];
        if (xr == 0 && yr == 0) begin
            return '0;
        end
        ang = 0;
        if (xr < 0) begin
            xr  = -xr;
            yr  = -yr;
            ang = HALF_TURN_Q16;
        end
        for (i = 0; i < CORDIC_ITERS; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (yr > 0) begin
                xr  = xr + dx;
                yr  = yr - dy;
                ang = ang + atan_lut[i];
            end else begin
                xr  = xr - dx;
                yr  = yr + dy;
                ang = ang - atan_lut[i];
            end
        end
        t = ((ang + ROUND_BIAS) / Q6_PER_STEP) % Q6_TURN;
        return t[HEAD_W-1:0];
    endfunction

    function automatic void add_row(input int g, input int sx, input int sy, input int sz,
                                    input bit known, input int hd);
        sample_row_t r;
        r.gain    = GAIN_W'(g);
        r.sx      = 13'(sx);
        r.sy      = 13'(sy);
        r.sz      = 13'(sz);
        r.known   = known;
        r.heading = HEAD_W'(hd);
        sample_rows.push_back(r);
    endfunction

    // one beat on the sample channel; handshake is sampled at the falling edge
    task automatic send_sample(input logic signed [12:0] sx, input logic signed [12:0] sy,
                               input logic signed [12:0] sz, input bit known,
                               input logic [HEAD_W-1:0] hd);
        bit ready;
        while ($urandom_range(99) < idle_in_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, sz, sy, sx};
        do begin
            @(negedge aclk);
            ready = s_tready;
            @(posedge aclk);
        end while (!ready);
        heading_q.push_back(known ? hd : predict_heading(sx, sy, sz));
    endtask

    task automatic send_random();
        logic signed [12:0] sx, sy, sz;
        int shape;
        shape = $urandom_range(99);
        sx = 13'($urandom);
        sy = 13'($urandom);
        sz = 13'($urandom);
        if (shape < 15) begin
            // near the x axis: hits the wrap at a full circle
            sy = 13'(int'($urandom_range(6)) - 3);
        end else if (shape < 25) begin
            sx = 13'(int'($urandom_range(8)) - 4);
            sy = 13'(int'($urandom_range(8)) - 4);
            sz = 13'(int'($urandom_range(8)) - 4);
        end
        send_sample(sx, sy, sz, 1'b0, '0);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (heading_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [GAIN_W-1:0] g, input logic [CFG_W-1:0] offs,
                                  input logic [CFG_W-1:0] rx, input logic [CFG_W-1:0] ry);
        logic [CFG_W-1:0] junk;
        drain_pipe();
        junk = rand48();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GAIN;
        cfg_wdata <= {junk[CFG_W-1:GAIN_W], g};   // upper bits are don't-care
        @(posedge aclk);
        cfg_index <= REG_OFFS;
        cfg_wdata <= offs;
        @(posedge aclk);
        cfg_index <= REG_ROT_X;
        cfg_wdata <= rx;
        @(posedge aclk);
        cfg_index <= REG_ROT_Y;
        cfg_wdata <= ry;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gain_sh = g;
        offs_sh = offs;
        rowx_sh = rx;
        rowy_sh = ry;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_out_pct);
    end

    // result checker and watchdog
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (heading_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected heading beat: expected none, actual %0d",
                         $time, m_tdata);
            end else begin
                want = heading_q.pop_front();
                if (m_tdata !== {1'b0, want}) begin
                    errors++;
                    $display("%0t: heading mismatch: expected %0d, actual %0d",
                             $time, want, m_tdata);
                end
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] offs, rx, ry;
        int c;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // gain, x, y, z, known, heading
        add_row(0, 0, 0, 0, 1, 0);
        add_row(0, 0, 0, 4095, 1, 0);       // z only: identity rotation leaves nothing
        add_row(0, 0, 0, -4096, 1, 0);
        add_row(0, 4095, 0, 0, 0, 0);
        add_row(0, -4096, 0, 0, 0, 0);
        add_row(0, 0, 4095, 0, 0, 0);
        add_row(0, 0, -4096, 0, 0, 0);
        add_row(0, 4095, -1, 0, 0, 0);      // just below zero degrees
        add_row(0, 4095, 1, 0, 0, 0);
        add_row(0, -4096, -1, 0, 0, 0);
        add_row(0, -4096, 1, 0, 0, 0);
        add_row(0, 4095, 4095, 4095, 0, 0);
        add_row(0, -4096, -4096, -4096, 0, 0);
        add_row(0, 1, 0, 0, 0, 0);
        add_row(0, -1, -1, 0, 0, 0);
        add_row(3, 1234, -2345, 77, 0, 0);
        add_row(6, 4095, -4096, 100, 0, 0);
        add_row(6, -1, 1, -1, 0, 0);
        add_row(7, 4095, -4096, 100, 0, 0);
        add_row(7, -4096, 4095, -4096, 0, 0);
        add_row(7, 0, 0, 0, 1, 0);

        foreach (sample_rows[i]) begin
            if (sample_rows[i].gain != gain_sh) begin
                write_settings(sample_rows[i].gain, offs_sh, rowx_sh, rowy_sh);
            end
            send_sample(sample_rows[i].sx, sample_rows[i].sy, sample_rows[i].sz,
                        sample_rows[i].known, sample_rows[i].heading);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            unique case (p)
                0: write_settings(3'd0, '0, ROT_X_RESET, ROT_Y_RESET);
                1: write_settings(3'd6, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}});
                2: write_settings(3'd7, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}});
                3: write_settings(GAIN_W'($urandom), rand48(), rand48(), rand48());
                4: begin
                    offs = pack_row(int'($urandom_range(1000)) - 500,
                                    int'($urandom_range(1000)) - 500,
                                    int'($urandom_range(1000)) - 500);
                    c  = 16384 + int'($urandom_range(4000)) - 2000;
                    rx = pack_row(c, int'($urandom_range(6000)) - 3000,
                                  int'($urandom_range(6000)) - 3000);
                    c  = 16384 + int'($urandom_range(4000)) - 2000;
                    ry = pack_row(int'($urandom_range(6000)) - 3000, c,
                                  int'($urandom_range(6000)) - 3000);
                    write_settings(GAIN_W'($urandom), offs, rx, ry);
                end
                5: write_settings(GAIN_W'($urandom), rand48(), '0, '0);  // always zero vector
                6: write_settings(GAIN_W'($urandom), rand48(), rand48(), rand48());
                default: begin
                    offs = pack_row(int'($urandom_range(200)) - 100,
                                    int'($urandom_range(200)) - 100,
                                    int'($urandom_range(200)) - 100);
                    write_settings(3'd3, offs, ROT_X_RESET, ROT_Y_RESET);
                end
            endcase
            if (p < 3) begin
                idle_in_pct   = 10;
                stall_out_pct = 82;
            end else if (p < 6) begin
                idle_in_pct   = 82;
                stall_out_pct = 10;
            end else begin
                idle_in_pct   = 0;
                stall_out_pct = 0;
            end
            repeat (PHASE_ITEMS) send_random();
        end

        drain_pipe();
        if (errors == 0 && heading_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
